// ===== hw/rtl/wbcs_pkg.sv =====
`default_nettype none
package wbcs_pkg;

	localparam int unsigned COUNT_W = 23;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 15;
	localparam int unsigned IMG_W_W = 12;
	localparam int unsigned ROW_CFG_W = 11;
	localparam int unsigned SPEED_W = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_FIRST = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_END = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FORWARD = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SEARCH = 3'd6;

	localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH = 12'd640;
	localparam logic [ROW_CFG_W-1:0] RST_BAND_FIRST = 11'd213;
	localparam logic [IMG_W_W-1:0] RST_BAND_END = 12'd267;
	localparam logic RST_RECOVERY = 1'b1;
	localparam logic [SPEED_W-1:0] RST_FORWARD = 15'd205;
	localparam logic [SPEED_W-1:0] RST_TURN = 15'd1024;
	localparam logic [SPEED_W-1:0] RST_SEARCH = 15'd10240;

	localparam logic [2:0] DIR_SEARCH = 3'd0;
	localparam logic [2:0] DIR_STOP = 3'd1;
	localparam logic [2:0] DIR_LEFT = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_FORWARD = 3'd4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic end_of_frame;
	} pix_t;

	typedef struct packed {
		logic [2:0] direction;
		logic [SPEED_W-1:0] linear_speed;
		logic signed [15:0] angular_speed;
	} res_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wbcs_accum.sv =====
`default_nettype none
module wbcs_accum
	import wbcs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 2048,
	parameter int unsigned MAX_HEIGHT = 2048,
	localparam int unsigned CW = $clog2(MAX_WIDTH),
	localparam int unsigned RW = $clog2(MAX_HEIGHT),
	localparam int unsigned SW = CW + COUNT_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire pix_t pix,
	input wire logic [IMG_W_W-1:0] eff_width,
	input wire logic [ROW_CFG_W-1:0] band_first,
	input wire logic [IMG_W_W-1:0] band_end,
	output logic [SW-1:0] frame_sum,
	output logic [COUNT_W-1:0] frame_count
);

	localparam int unsigned XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int unsigned BW = (RW > IMG_W_W) ? RW : IMG_W_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] sum_q;
	logic [COUNT_W-1:0] count_q;

	logic white;
	logic in_band;
	logic add;
	logic [CW:0] col_plus;
	logic wrap;

	assign white = (&pix.red) && (&pix.green) && (&pix.blue);
	assign in_band = (BW'(row_q) >= BW'(band_first)) && (BW'(row_q) < BW'(band_end));
	assign add = white && in_band && (count_q != COUNT_MAX);
	assign col_plus = {1'b0, col_q} + 1'b1;
	assign wrap = XW'(col_plus) >= XW'(eff_width);

	assign frame_sum = add ? sum_q + SW'(col_q) : sum_q;
	assign frame_count = add ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (pix.end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= frame_sum;
				count_q <= frame_count;
				if (wrap) begin
					col_q <= '0;
					row_q <= (row_q == RW'(MAX_HEIGHT - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_plus[CW-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wbcs_divider.sv =====
`default_nettype none
module wbcs_divider
	import wbcs_pkg::*;
#(
	parameter int unsigned CW = 11,
	localparam int unsigned SW = CW + COUNT_W,
	localparam int unsigned STW = $clog2(CW + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SW-1:0] dividend,
	input wire logic [COUNT_W-1:0] divisor,
	output logic busy,
	output logic [CW-1:0] quotient
);

	logic busy_q;
	logic [STW-1:0] step_q;
	logic [COUNT_W-1:0] rem_q;
	logic [CW-1:0] quo_q;
	logic [COUNT_W-1:0] divisor_q;

	logic [COUNT_W+1:0] diff;
	logic ge;

	assign diff = {1'b0, rem_q, quo_q[CW-1]} - {2'b00, divisor_q};
	assign ge = !diff[COUNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STW'(CW - 1)) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SW-1:CW];
			quo_q <= dividend[CW-1:0];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : {rem_q[COUNT_W-2:0], quo_q[CW-1]};
			quo_q <= {quo_q[CW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/white_blob_centroid_steering.sv =====
// white blob centroid steering
//
// in channel: one rgb pixel per item on in_valid/in_stall, raster order; the
// block tracks column and row itself and the item with end_of_frame set closes
// the frame. out channel: one steering item per frame on out_valid/out_stall.
// cfg: write cfg_we with cfg_index and cfg_data, only while no frame result is
// pending.
// pixels are taken one per cycle while in_stall is low. the end-of-frame item
// stalls the input while the mean column is formed: with white pixels seen in
// the band, a restoring divider runs one quotient bit per cycle, then the
// sequencer leaves the divide state and the done state registers the result,
// after which the next pixel can enter. with no white pixel in the band the
// sequencer goes straight to the done state. while out_stall holds a finished
// result, the next frame's pixels are still taken; a second result waits in
// the sequencer and stalls the input until the output register frees.
// reset clears the counters, the sums and out_valid, and loads the register
// defaults (width 640, band rows 213 to 266, recovery on).
`default_nettype none
module white_blob_centroid_steering
	import wbcs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire pix_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output res_t out_data,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned SW = CW + COUNT_W;
	localparam int unsigned CAP = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
	localparam int unsigned CMPW = (CW + 2 > IMG_W_W + 1) ? CW + 2 : IMG_W_W + 1;

	logic [IMG_W_W-1:0] width_q;
	logic [ROW_CFG_W-1:0] band_first_q;
	logic [IMG_W_W-1:0] band_end_q;
	logic recovery_q;
	logic [SPEED_W-1:0] forward_q;
	logic [SPEED_W-1:0] turn_q;
	logic [SPEED_W-1:0] search_q;

	state_t state_q;
	state_t state_nx;
	logic none_q;
	logic out_valid_q;
	res_t out_q;

	logic [IMG_W_W-1:0] eff_width;
	logic take;
	logic eof_take;
	logic [SW-1:0] frame_sum;
	logic [COUNT_W-1:0] frame_count;
	logic div_start;
	logic div_busy;
	logic [CW-1:0] mean;
	logic [CMPW-1:0] mean3;
	logic go_left;
	logic go_right;
	logic out_load;
	res_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_IMAGE_WIDTH;
			band_first_q <= RST_BAND_FIRST;
			band_end_q <= RST_BAND_END;
			recovery_q <= RST_RECOVERY;
			forward_q <= RST_FORWARD;
			turn_q <= RST_TURN;
			search_q <= RST_SEARCH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[IMG_W_W-1:0];
				REG_BAND_FIRST: band_first_q <= cfg_data[ROW_CFG_W-1:0];
				REG_BAND_END: band_end_q <= cfg_data[IMG_W_W-1:0];
				REG_RECOVERY: recovery_q <= cfg_data[0];
				REG_FORWARD: forward_q <= cfg_data[SPEED_W-1:0];
				REG_TURN: turn_q <= cfg_data[SPEED_W-1:0];
				REG_SEARCH: search_q <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_width = IMG_W_W'(1);
		end else if (width_q > IMG_W_W'(CAP)) begin
			eff_width = IMG_W_W'(CAP);
		end else begin
			eff_width = width_q;
		end
	end

	assign in_stall = (state_q != ST_ACCUM);
	assign take = in_valid && !in_stall;
	assign eof_take = take && in_data.end_of_frame;
	assign div_start = eof_take && (frame_count != '0);

	wbcs_accum #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.pix(in_data),
		.eff_width(eff_width),
		.band_first(band_first_q),
		.band_end(band_end_q),
		.frame_sum(frame_sum),
		.frame_count(frame_count)
	);

	wbcs_divider #(
		.CW(CW)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(frame_sum),
		.divisor(frame_count),
		.busy(div_busy),
		.quotient(mean)
	);

	// mean < w/3 and mean > 2w/3, both truncating, without a divide
	assign mean3 = (CMPW'(mean) << 1) + CMPW'(mean);
	assign go_left = (mean3 + CMPW'(3)) <= CMPW'(eff_width);
	assign go_right = mean3 > (CMPW'(eff_width) << 1);

	always_comb begin
		result.direction = DIR_FORWARD;
		result.linear_speed = forward_q;
		result.angular_speed = '0;
		if (none_q) begin
			result.linear_speed = '0;
			if (recovery_q) begin
				result.direction = DIR_SEARCH;
				result.angular_speed = $signed({1'b0, search_q});
			end else begin
				result.direction = DIR_STOP;
			end
		end else if (go_left) begin
			result.direction = DIR_LEFT;
			result.angular_speed = $signed({1'b0, turn_q});
		end else if (go_right) begin
			result.direction = DIR_RIGHT;
			result.angular_speed = -$signed({1'b0, turn_q});
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (eof_take) begin
					state_nx = (frame_count != '0) ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_nx = ST_ACCUM;
				end
			end
			default: state_nx = ST_ACCUM;
		endcase
	end

	always_comb begin
		out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			none_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (eof_take) begin
				none_q <= (frame_count == '0);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> in_stall)
		else $error("pixel taken while divider busy");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_DONE)
		else $error("divide state left for accumulate");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_eof_leaves_accum: assert property (@(posedge clk) disable iff (!arst_n)
		eof_take |=> state_q != ST_ACCUM)
		else $error("end of frame did not start result");

endmodule
`default_nettype wire
